[rtl/rlcf_pkg.sv]
// Shared types and constants for the linear RGB color fade block.
package rlcf_pkg;

	localparam int COLOR_W   = 8;
	localparam int TIME_W    = 16;
	localparam int DUR_W     = 20;
	localparam int POS_W     = 8;
	localparam int LEN_SHIFT = 4;
	localparam int CNT_W     = $clog2(POS_W);
	localparam int NCH       = 3;

	typedef enum logic [1:0] {
		KIND_SET   = 2'd0,
		KIND_START = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PENDING = 2'd1,
		PH_FADING  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_BLEND,
		S_PUSH_BASE,
		S_PUSH_MIX
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic div_step;
		logic blend;
		logic push;
		logic mix;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_sts_t;

endpackage

[rtl/rlcf_dp.sv]
// Datapath: fade state, request latch, bit-serial position divider, blend and result register.
module rlcf_dp #(
	parameter int MAX_DURATION_MS = 65535
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rlcf_pkg::dp_cmd_t               cmd,
	output rlcf_pkg::dp_sts_t               sts,
	input  logic [1:0]                      kind,
	input  logic [rlcf_pkg::COLOR_W-1:0]    red,
	input  logic [rlcf_pkg::COLOR_W-1:0]    green,
	input  logic [rlcf_pkg::COLOR_W-1:0]    blue,
	input  logic [rlcf_pkg::DUR_W-1:0]      fade_ms,
	input  logic [rlcf_pkg::TIME_W-1:0]     now_16ms,
	output logic [rlcf_pkg::COLOR_W-1:0]    out_red,
	output logic [rlcf_pkg::COLOR_W-1:0]    out_green,
	output logic [rlcf_pkg::COLOR_W-1:0]    out_blue,
	output logic [1:0]                      phase
);
	import rlcf_pkg::*;

	localparam int LEN_W = $clog2((MAX_DURATION_MS >> LEN_SHIFT) + 1);
	localparam logic [DUR_W-1:0] MAX_D = DUR_W'(MAX_DURATION_MS);

	// fade state
	logic [NCH-1:0][COLOR_W-1:0] base_q, goal_q;
	logic [LEN_W-1:0]            len_q;
	logic [TIME_W-1:0]           start_q;
	phase_t                      phase_q;

	// request latch
	logic [1:0]                  kind_q;
	logic [NCH-1:0][COLOR_W-1:0] rgb_q;
	logic [DUR_W-1:0]            dur_q;
	logic [TIME_W-1:0]           now_q;

	// divider and blend
	logic [LEN_W-1:0]            rem_q;
	logic [POS_W-1:0]            quo_q;
	logic [NCH-1:0][COLOR_W-1:0] mix_q;

	// result register
	logic [NCH-1:0][COLOR_W-1:0] res_q;
	logic [1:0]                  res_phase_q;

	logic [TIME_W-1:0]           elapsed;
	logic                        colors_eq;
	logic [DUR_W-1:0]            dsat;
	logic [LEN_W-1:0]            len_nxt;
	logic [LEN_W:0]              rem_dbl;
	logic                        rem_ge;
	logic [LEN_W-1:0]            rem_nxt;
	logic [NCH-1:0][COLOR_W-1:0] mix;
	logic signed [COLOR_W:0]     diff   [NCH];
	logic signed [2*COLOR_W+1:0] prod   [NCH];
	logic signed [2*COLOR_W+1:0] stepv  [NCH];

	assign elapsed   = now_q - start_q;
	assign colors_eq = (base_q == goal_q);
	assign dsat      = (dur_q > MAX_D) ? MAX_D : dur_q;
	assign len_nxt   = LEN_W'(dsat >> LEN_SHIFT);

	assign sts.need_div = (kind_q == KIND_READ) && (phase_q == PH_FADING) &&
		(now_q != start_q) && (elapsed < TIME_W'(len_q));

	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = (rem_dbl >= {1'b0, len_q});
	assign rem_nxt = rem_ge ? LEN_W'(rem_dbl - {1'b0, len_q}) : LEN_W'(rem_dbl);

	// base + floor((goal - base) * pos / 256)
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			diff[i]  = $signed({1'b0, goal_q[i]}) - $signed({1'b0, base_q[i]});
			prod[i]  = diff[i] * $signed({1'b0, quo_q});
			stepv[i] = prod[i] >>> POS_W;
			mix[i]   = base_q[i] + stepv[i][COLOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			goal_q  <= '0;
			len_q   <= '0;
			start_q <= '0;
			phase_q <= PH_IDLE;
		end else if (cmd.exec) begin
			case (kind_q)
				KIND_SET: begin
					goal_q <= rgb_q;
					if (rgb_q == base_q) begin
						phase_q <= PH_IDLE;
					end else if (phase_q != PH_FADING) begin
						phase_q <= PH_PENDING;
					end
				end
				KIND_START: begin
					if (colors_eq) begin
						phase_q <= PH_IDLE;
					end else if (dur_q == '0) begin
						base_q  <= goal_q;
						phase_q <= PH_IDLE;
					end else begin
						len_q   <= len_nxt;
						start_q <= now_q;
						phase_q <= PH_FADING;
					end
				end
				KIND_READ: begin
					// fade over: elapsed reached the length
					if (phase_q == PH_FADING && now_q != start_q && !sts.need_div) begin
						base_q  <= goal_q;
						phase_q <= PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			rgb_q  <= {blue, green, red};
			dur_q  <= fade_ms;
			now_q  <= now_16ms;
		end
		if (cmd.exec) begin
			rem_q <= LEN_W'(elapsed);
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[POS_W-2:0], rem_ge};
		end
		if (cmd.blend) begin
			mix_q <= mix;
		end
		if (cmd.push) begin
			res_q       <= cmd.mix ? mix_q : base_q;
			res_phase_q <= phase_q;
		end
	end

	assign out_red   = res_q[0];
	assign out_green = res_q[1];
	assign out_blue  = res_q[2];
	assign phase     = res_phase_q;

	a_mix_fading: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && cmd.mix) |-> (phase_q == PH_FADING))
		else $error("blended result outside a fade");

	a_div_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && sts.need_div) |=> (phase_q == PH_FADING && $stable(base_q)))
		else $error("state changed on a blended read");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < len_q))
		else $error("divider remainder out of range");

endmodule

[rtl/rlcf_ctrl.sv]
// Controller: request sequencing, divider step count and result handshake.
module rlcf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rlcf_pkg::dp_cmd_t   cmd,
	input  rlcf_pkg::dp_sts_t   sts
);
	import rlcf_pkg::*;

	state_t           state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = sts.need_div ? S_DIV : S_PUSH_BASE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(POS_W - 1)) begin
					state_nxt = S_BLEND;
				end
			end
			S_BLEND: begin
				cmd.blend = 1'b1;
				state_nxt = S_PUSH_MIX;
			end
			S_PUSH_BASE: begin
				if (out_free) begin
					cmd.push  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_PUSH_MIX: begin
				if (out_free) begin
					cmd.push  = 1'b1;
					cmd.mix   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && sts.need_div) |=> (state_q == S_DIV && cnt_q == '0))
		else $error("divider not started");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BLEND) |-> ($past(state_q) == S_DIV &&
		$past(cnt_q) == CNT_W'(POS_W - 1)))
		else $error("blend without a full division");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || !rsp_stall))
		else $error("result overwritten while held");

endmodule

[rtl/rgb_linear_color_fade.sv]
// Top level of the linear RGB color fade block.
//
//  channel  | handshake             | payload
//  request  | req_valid, req_stall  | kind, red, green, blue, fade_ms, now_16ms
//  result   | rsp_valid, rsp_stall  | out_red, out_green, out_blue, phase
//
// A request runs from accept through exec and push to the result; for a read in mid fade
// an 8-step restoring divider forms the position one bit per cycle before the blend.
// One request is in work at a time; a finished result sits in the output register
// and the next request is accepted while it waits.
// A stalled result holds; a new result waits until the held one is taken.
// Reset clears the fade state to black, idle.
module rgb_linear_color_fade #(
	parameter int MAX_DURATION_MS = 65535
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [1:0]                      kind,
	input  logic [rlcf_pkg::COLOR_W-1:0]    red,
	input  logic [rlcf_pkg::COLOR_W-1:0]    green,
	input  logic [rlcf_pkg::COLOR_W-1:0]    blue,
	input  logic [rlcf_pkg::DUR_W-1:0]      fade_ms,
	input  logic [rlcf_pkg::TIME_W-1:0]     now_16ms,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [rlcf_pkg::COLOR_W-1:0]    out_red,
	output logic [rlcf_pkg::COLOR_W-1:0]    out_green,
	output logic [rlcf_pkg::COLOR_W-1:0]    out_blue,
	output logic [1:0]                      phase
);
	import rlcf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rlcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rlcf_dp #(
		.MAX_DURATION_MS (MAX_DURATION_MS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (kind),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.fade_ms     (fade_ms),
		.now_16ms    (now_16ms),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.phase       (phase)
	);

endmodule
